### hdl/cdc_pkg.sv
`timescale 1ns / 1ps
package cdc_pkg;
	localparam int MAX_AXES     = 3;
	localparam int MAX_KERNEL   = 4;
	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_DEPTH = 4096;
	localparam int SAW          = $clog2(SAMPLE_DEPTH);
	localparam int MAX_TAPS     = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL;
	localparam int TAPW         = $clog2(MAX_TAPS);
	localparam int NKW          = TAPW + 1;
	localparam int WEIGHT_DEPTH = MAX_TAPS * MAX_CHANNELS;
	localparam int WAW          = $clog2(WEIGHT_DEPTH);
	localparam int CHW          = $clog2(MAX_CHANNELS);
	localparam int KW           = $clog2(MAX_KERNEL);

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [2:0] REG_NUM_AXES = 3'd0;
	localparam logic [2:0] REG_SIZE0    = 3'd1;
	localparam logic [2:0] REG_SIZE1    = 3'd2;
	localparam logic [2:0] REG_SIZE2    = 3'd3;
	localparam logic [2:0] REG_KERNEL   = 3'd4;
	localparam logic [2:0] REG_CHANNELS = 3'd5;
	localparam logic [2:0] REG_BIAS_EN  = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_A0, ST_A1, ST_A2, ST_WRITE, ST_TAP, ST_READ, ST_MAC,
		ST_FIN, ST_OUT
	} state_t;
endpackage

### hdl/cdc_ram.sv
`timescale 1ns / 1ps
module cdc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/causal_depthwise_conv_nd.sv
`timescale 1ns / 1ps
// Sequential block: one beat at a time, ready only in idle. T = K^N taps.
// Per sample: decode, three address steps and the store, then each of the T taps; a tap in the
// causal padding is only checked and dropped, any other tap runs check, three address steps,
// read and multiply-accumulate, all on one shared multiplier; then the result is offered.
// The next beat is taken only once the result has left; a load returns to idle after decode.
// arst_n clears config to its defaults, position and channel index to zero; stores hold garbage.
module causal_depthwise_conv_nd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [8:0]  table_index,
	input  logic signed [15:0] value,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] result_value,
	output logic        last
);
	import cdc_pkg::*;

	// configuration registers
	logic [1:0]  num_axes_q;
	logic [12:0] size0_q, size1_q, size2_q;
	logic [2:0]  kernel_q;
	logic [3:0]  channels_q;
	logic        bias_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_axes_q <= 2'd2; size0_q <= 13'd16; size1_q <= 13'd16; size2_q <= 13'd1;
			kernel_q <= 3'd3; channels_q <= 4'd1; bias_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_AXES: num_axes_q <= cfg_data[1:0];
				REG_SIZE0:    size0_q <= cfg_data;
				REG_SIZE1:    size1_q <= cfg_data;
				REG_SIZE2:    size2_q <= cfg_data;
				REG_KERNEL:   kernel_q <= cfg_data[2:0];
				REG_CHANNELS: channels_q <= cfg_data[3:0];
				REG_BIAS_EN:  bias_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped configuration
	logic [1:0]  n_c;
	logic [2:0]  k_c;
	logic [3:0]  d_c;
	logic [12:0] dim0, dim1, dim2;

	function automatic logic [12:0] clamp_ext(input logic [12:0] v);
		if (v == 13'd0) return 13'd1;
		if (v > 13'd4096) return 13'd4096;
		return v;
	endfunction

	always_comb begin
		n_c  = (num_axes_q == 2'd0) ? 2'd1 : num_axes_q;
		k_c  = (kernel_q == 3'd0) ? 3'd1 : ((kernel_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kernel_q);
		d_c  = (channels_q == 4'd0) ? 4'd1 :
			((channels_q > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : channels_q);
		dim0 = clamp_ext(size0_q);
		dim1 = (n_c >= 2'd2) ? clamp_ext(size1_q) : 13'd1;
		dim2 = (n_c >= 2'd3) ? clamp_ext(size2_q) : 13'd1;
	end

	// number of taps K^N
	logic [NKW-1:0] nk_w;
	always_comb begin
		unique case (n_c)
			2'd1:    nk_w = NKW'(k_c);
			2'd2:    nk_w = NKW'(k_c) * NKW'(k_c);
			default: nk_w = NKW'(k_c) * NKW'(k_c) * NKW'(k_c);
		endcase
	end

	// floor-shifted sum saturated to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) return 32'sh7fffffff;
		if (v < -40'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// state
	state_t state_q, state_d;
	logic [12:0] pos0_q, pos1_q, pos2_q;
	logic [CHW-1:0] ch_q;
	logic [1:0]  op_q;
	logic [8:0]  idx_q;
	logic signed [15:0] val_q;
	logic        frame_start_q;
	logic        wr_pend_q;           // own sample still to be stored
	logic [KW-1:0] t0_q, t1_q, t2_q;  // tap digit per axis
	logic [TAPW-1:0] tap_q;           // linear tap index
	logic [WAW-1:0] waddr_q;          // weight address tap*D + channel
	logic [12:0] s0_q, s1_q, s2_q;    // source coordinates
	logic [SAW-1:0] addr_q;           // sample store address
	logic signed [39:0] acc_q;
	logic signed [31:0] res_q;
	logic        last_q;

	// memories
	logic        s_we, w_we, b_we;
	logic [15:0] s_rdata, w_rdata, b_rdata;

	cdc_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_samples (
		.clk(clk), .we(s_we), .waddr(addr_q), .wdata(val_q), .raddr(addr_q), .rdata(s_rdata));
	cdc_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weights (
		.clk(clk), .we(w_we), .waddr(idx_q[WAW-1:0]), .wdata(val_q), .raddr(waddr_q),
		.rdata(w_rdata));
	cdc_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_bias (
		.clk(clk), .we(b_we), .waddr(idx_q[CHW-1:0]), .wdata(val_q), .raddr(ch_q),
		.rdata(b_rdata));

	// position check: restart at position 0, channel 0 on frame start or
	// when the stored position no longer fits the configuration
	logic        in_range, restart;
	logic [12:0] p0_f, p1_f, p2_f;
	logic [CHW-1:0] ch_f;
	assign in_range = (pos0_q < dim0) && (pos1_q < dim1) && (pos2_q < dim2) &&
		(4'(ch_q) < d_c);
	assign restart = frame_start_q || !in_range;
	assign p0_f = restart ? 13'd0 : pos0_q;
	assign p1_f = restart ? 13'd0 : pos1_q;
	assign p2_f = restart ? 13'd0 : pos2_q;
	assign ch_f = restart ? '0 : ch_q;

	// tap offsets: back = K-1-digit on axes in use, zero on the others;
	// drop the tap if any source coordinate would go below zero
	logic [2:0] b0, b1, b2;
	logic       okc, tap_last;
	always_comb begin
		b0 = k_c - 3'd1 - 3'(t0_q);
		b1 = (n_c >= 2'd2) ? k_c - 3'd1 - 3'(t1_q) : 3'd0;
		b2 = (n_c == 2'd3) ? k_c - 3'd1 - 3'(t2_q) : 3'd0;
		okc = (pos0_q >= 13'(b0)) && (pos1_q >= 13'(b1)) && (pos2_q >= 13'(b2));
		tap_last = (NKW'(tap_q) == nk_w - NKW'(1));
	end

	// shared multiplier: address steps (lin*dim + coord, mod depth) and the tap MAC
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] mul_p;
	logic [SAW-1:0]     mul_add;
	always_comb begin
		mul_a   = 17'(s0_q);
		mul_b   = 17'(dim1);
		mul_add = SAW'(s1_q);
		unique case (state_q)
			ST_A1: begin
				mul_a = 17'(addr_q); mul_b = 17'(dim2); mul_add = SAW'(s2_q);
			end
			ST_A2: begin
				mul_a = 17'(addr_q); mul_b = 17'(d_c); mul_add = SAW'(ch_q);
			end
			ST_MAC: begin
				mul_a = 17'($signed(w_rdata)); mul_b = 17'($signed(s_rdata)); mul_add = '0;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign result_value = res_q;
	assign last = last_q;

	always_comb begin
		state_d = state_q;
		s_we = 1'b0; w_we = 1'b0; b_we = 1'b0;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				if (op_q == OP_WEIGHT) begin
					w_we = 1'b1;
					state_d = ST_IDLE;
				end else if (op_q == OP_BIAS) begin
					b_we = (idx_q < 9'(MAX_CHANNELS));
					state_d = ST_IDLE;
				end else if (op_q == OP_SAMPLE) begin
					state_d = ST_A0;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_A0:    state_d = ST_A1;
			ST_A1:    state_d = ST_A2;
			ST_A2:    state_d = wr_pend_q ? ST_WRITE : ST_READ;
			ST_WRITE: begin s_we = 1'b1; state_d = ST_TAP; end
			ST_TAP: begin
				if (okc) state_d = ST_A0;
				else if (tap_last) state_d = ST_FIN;
			end
			ST_READ:  state_d = ST_MAC;
			ST_MAC:   state_d = tap_last ? ST_FIN : ST_TAP;
			ST_FIN:   state_d = ST_OUT;
			ST_OUT:   if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// position and channel: fix on decode, advance when the result beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos0_q <= '0; pos1_q <= '0; pos2_q <= '0; ch_q <= '0;
		end else if (state_q == ST_DECODE && op_q == OP_SAMPLE) begin
			pos0_q <= p0_f; pos1_q <= p1_f; pos2_q <= p2_f; ch_q <= ch_f;
		end else if (state_q == ST_OUT && out_ready) begin
			if (4'(ch_q) + 4'd1 >= d_c) begin
				ch_q <= '0;
				if (pos2_q + 13'd1 < dim2) pos2_q <= pos2_q + 13'd1;
				else begin
					pos2_q <= '0;
					if (pos1_q + 13'd1 < dim1) pos1_q <= pos1_q + 13'd1;
					else begin
						pos1_q <= '0;
						pos0_q <= (pos0_q + 13'd1 < dim0) ? pos0_q + 13'd1 : '0;
					end
				end
			end else begin
				ch_q <= ch_q + CHW'(1);
			end
		end
	end

	// datapath: payload registers, no reset
	always_ff @(posedge clk) begin
		case (state_q) inside
			ST_IDLE: begin
				if (in_valid) begin
					op_q <= opcode; idx_q <= table_index; val_q <= value;
					frame_start_q <= frame_start;
				end
			end
			ST_DECODE: begin
				// first address pass targets the own position for the store
				s0_q <= p0_f; s1_q <= p1_f; s2_q <= p2_f;
				wr_pend_q <= 1'b1;
				t0_q <= '0; t1_q <= '0; t2_q <= '0; tap_q <= '0;
				waddr_q <= WAW'(ch_f);
			end
			ST_A0, ST_A1, ST_A2: addr_q <= mul_p[SAW-1:0] + mul_add;
			ST_WRITE: begin
				wr_pend_q <= 1'b0;
				acc_q <= bias_en_q ? (40'($signed(b_rdata)) <<< 15) : '0;
			end
			ST_TAP: begin
				// hold source coords for this tap
				s0_q <= pos0_q - 13'(b0); s1_q <= pos1_q - 13'(b1); s2_q <= pos2_q - 13'(b2);
			end
			ST_MAC: acc_q <= acc_q + 40'(mul_p);
			ST_FIN: begin
				res_q <= sat32(acc_q >>> 15);
				last_q <= (4'(ch_q) == d_c - 4'd1) && (pos0_q == dim0 - 13'd1) &&
					(pos1_q == dim1 - 13'd1) && (pos2_q == dim2 - 13'd1);
			end
			default: ;
		endcase
		// advance to the next tap after a MAC or a dropped tap
		if ((state_q == ST_MAC) || (state_q == ST_TAP && !okc)) begin
			tap_q <= tap_q + TAPW'(1);
			waddr_q <= waddr_q + WAW'(d_c);
			if (n_c == 2'd1) begin
				t0_q <= t0_q + KW'(1);
			end else if (n_c == 2'd2) begin
				if (3'(t1_q) + 3'd1 >= k_c) begin t1_q <= '0; t0_q <= t0_q + KW'(1); end
				else t1_q <= t1_q + KW'(1);
			end else begin
				if (3'(t2_q) + 3'd1 >= k_c) begin
					t2_q <= '0;
					if (3'(t1_q) + 3'd1 >= k_c) begin t1_q <= '0; t0_q <= t0_q + KW'(1); end
					else t1_q <= t1_q + KW'(1);
				end else t2_q <= t2_q + KW'(1);
			end
		end
	end
endmodule
